// ----- hw/rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Types, codes and sizes shared by the subsequence stack matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int MAX_WORD_LEN = 1024;
  localparam int STACK_DEPTH  = 1024;
  localparam int ALPHABET     = 26;

  localparam int REQ_W  = 2;
  localparam int LTR_W  = 5;
  localparam int POS_W  = 11;
  localparam int WIDX_W = $clog2(MAX_WORD_LEN);
  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int LIDX_W = $clog2(ALPHABET);

  localparam logic [POS_W-1:0] NONE_POS = POS_W'(MAX_WORD_LEN);

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_PUSH   = 2'd1,
    REQ_POP    = 2'd2
  } ssm_req_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POP_EMPTY  = 2'd1,
    STAT_STACK_FULL = 2'd2,
    STAT_WORD_FULL  = 2'd3
  } ssm_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_POP_RD,
    S_POP_LOAD,
    S_DONE
  } ssm_state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [LTR_W-1:0] letter;
  } ssm_in_t;

  typedef struct packed {
    logic             answer_yes;
    logic [POS_W-1:0] matched_position;
    ssm_status_e      status;
  } ssm_out_t;

  typedef struct packed {
    logic        load_req;
    logic        append;
    logic        search_init;
    logic        search_step;
    logic        push_commit;
    logic        pop_commit;
    logic        pop_load;
    logic        err;
    ssm_status_e err_code;
    logic        out_load;
  } ssm_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             word_full;
    logic             stack_full;
    logic             stack_empty;
    logic             pop_to_empty;
    logic             search_done;
  } ssm_stat_t;

endpackage

// ----- hw/rtl/ssm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: decodes a request, runs the search loop and the pop read, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ssm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ssm_pkg::ssm_stat_t stat_i,
  output ssm_pkg::ssm_cmd_t  cmd_o
);
  import ssm_pkg::*;

  ssm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.err_code = STAT_OK;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.req)
          REQ_APPEND: begin
            if (stat_i.word_full) begin
              cmd_o.err      = 1'b1;
              cmd_o.err_code = STAT_WORD_FULL;
            end else begin
              cmd_o.append = 1'b1;
            end
            state_d = S_DONE;
          end
          REQ_PUSH: begin
            if (stat_i.stack_full) begin
              cmd_o.err      = 1'b1;
              cmd_o.err_code = STAT_STACK_FULL;
              state_d        = S_DONE;
            end else begin
              cmd_o.search_init = 1'b1;
              state_d           = S_SRCH_RD;
            end
          end
          REQ_POP: begin
            if (stat_i.stack_empty) begin
              cmd_o.err      = 1'b1;
              cmd_o.err_code = STAT_POP_EMPTY;
              state_d        = S_DONE;
            end else begin
              cmd_o.pop_commit = 1'b1;
              state_d          = stat_i.pop_to_empty ? S_DONE : S_POP_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SRCH_RD: begin
        if (stat_i.search_done) begin
          cmd_o.push_commit = 1'b1;
          state_d           = S_DONE;
        end else begin
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.search_step = 1'b1;
        state_d           = S_SRCH_RD;
      end
      S_POP_RD: state_d = S_POP_LOAD;
      S_POP_LOAD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/ssm_datapath.sv -----
// ----------------------------------------------------------------------------
// ssm_datapath
// Word and stack storage, letter counts, binary search registers and the
// result and output registers.
// ----------------------------------------------------------------------------
module ssm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssm_pkg::ssm_in_t   in_beat_i,
  input  ssm_pkg::ssm_cmd_t  cmd_i,
  output ssm_pkg::ssm_stat_t stat_o,
  output ssm_pkg::ssm_out_t  out_beat_o
);
  import ssm_pkg::*;

  logic [WIDX_W-1:0] pos_mem [ALPHABET*MAX_WORD_LEN];
  logic [POS_W-1:0]  stk_mem [STACK_DEPTH];

  logic [REQ_W-1:0]  req_q;
  logic [LTR_W-1:0]  lt_q;
  logic [POS_W-1:0]  wlen_q;
  logic [POS_W-1:0]  depth_q;
  logic [POS_W-1:0]  counts_q [ALPHABET];
  logic [POS_W-1:0]  top_q;
  logic [POS_W-1:0]  lo_q, hi_q, cand_q;
  logic              bound_q;
  logic [WIDX_W-1:0] pos_rd_q;
  logic [POS_W-1:0]  stk_rd_q;
  ssm_out_t          res_q, out_q;

  logic              lt_ok;
  logic [LIDX_W-1:0] lt_idx;
  logic [POS_W-1:0]  cnt_sel;
  logic [POS_W-1:0]  mid;
  logic [LIDX_W+WIDX_W-1:0] pos_addr;
  logic [SIDX_W-1:0] stk_raddr;
  logic              no_match;

  assign lt_ok     = lt_q < LTR_W'(ALPHABET);
  assign lt_idx    = lt_q[LIDX_W-1:0];
  assign cnt_sel   = lt_ok ? counts_q[lt_idx] : '0;
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign pos_addr  = cmd_i.append ? {lt_idx, cnt_sel[WIDX_W-1:0]}
                                  : {lt_idx, mid[WIDX_W-1:0]};
  assign stk_raddr = SIDX_W'(depth_q - 1'b1);
  assign no_match  = !lt_ok || ((depth_q != '0) && (top_q == NONE_POS));

  assign stat_o.req          = req_q;
  assign stat_o.word_full    = wlen_q >= POS_W'(MAX_WORD_LEN);
  assign stat_o.stack_full   = depth_q >= POS_W'(STACK_DEPTH);
  assign stat_o.stack_empty  = depth_q == '0;
  assign stat_o.pop_to_empty = depth_q == POS_W'(1);
  assign stat_o.search_done  = lo_q >= hi_q;
  assign out_beat_o          = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && lt_ok) begin
      pos_mem[pos_addr] <= wlen_q[WIDX_W-1:0];
    end
    pos_rd_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_commit) begin
      stk_mem[depth_q[SIDX_W-1:0]] <= cand_q;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= '0;
      depth_q  <= '0;
      counts_q <= '{default: '0};
    end else begin
      if (cmd_i.append) begin
        wlen_q <= wlen_q + 1'b1;
        if (lt_ok) begin
          counts_q[lt_idx] <= counts_q[lt_idx] + 1'b1;
        end
      end
      if (cmd_i.push_commit) begin
        depth_q <= depth_q + 1'b1;
      end else if (cmd_i.pop_commit) begin
        depth_q <= depth_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_beat_i.req_type;
      lt_q  <= in_beat_i.letter;
    end
    if (cmd_i.search_init) begin
      lo_q    <= '0;
      hi_q    <= no_match ? '0 : cnt_sel;
      cand_q  <= NONE_POS;
      bound_q <= depth_q != '0;
    end else if (cmd_i.search_step) begin
      if (bound_q && (pos_rd_q <= top_q[WIDX_W-1:0])) begin
        lo_q <= mid + 1'b1;
      end else begin
        hi_q   <= mid;
        cand_q <= {1'b0, pos_rd_q};
      end
    end
    if (cmd_i.push_commit) begin
      top_q <= cand_q;
    end else if (cmd_i.pop_load) begin
      top_q <= stk_rd_q;
    end
    if (cmd_i.err) begin
      res_q.answer_yes       <= 1'b0;
      res_q.matched_position <= NONE_POS;
      res_q.status           <= cmd_i.err_code;
    end else if (cmd_i.append) begin
      res_q.answer_yes       <= 1'b0;
      res_q.matched_position <= wlen_q;
      res_q.status           <= STAT_OK;
    end else if (cmd_i.push_commit) begin
      res_q.answer_yes       <= cand_q != NONE_POS;
      res_q.matched_position <= cand_q;
      res_q.status           <= STAT_OK;
    end else if (cmd_i.pop_commit) begin
      // popping the last entry leaves an empty pattern, which always matches
      res_q.answer_yes       <= 1'b1;
      res_q.matched_position <= NONE_POS;
      res_q.status           <= STAT_OK;
    end else if (cmd_i.pop_load) begin
      res_q.answer_yes       <= stk_rd_q != NONE_POS;
      res_q.matched_position <= stk_rd_q;
      res_q.status           <= STAT_OK;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

endmodule

// ----- hw/rtl/subsequence_stack_matcher_core.sv -----
// ----------------------------------------------------------------------------
// subsequence_stack_matcher_core
// Loads a word letter by letter and tracks whether a pushed/popped pattern is
// still a subsequence, using a binary search over per-letter position lists.
// ----------------------------------------------------------------------------
//   channel | dir | handshake             | beat
//   --------+-----+-----------------------+-------------------------------
//   in      | in  | in_valid_i/in_stall_o | req_type, letter
//   out     | out | out_valid_o/out_stall_i | answer_yes, matched_position,
//           |     |                       |   status
//
// Append and error beats go DECODE to DONE; request type 3 gives no result. Pop
// goes to DONE directly or via POP_RD, POP_LOAD. Push loops SRCH_RD/SRCH_CMP about
// log2(letter count) steps, each waiting on the registered position memory read.
// Reset clears counts, word length and stack depth at once; no clearing pass.
// The block takes a new beat while a result waits in the output register.
// ----------------------------------------------------------------------------
module subsequence_stack_matcher_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ssm_pkg::ssm_in_t in_beat_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ssm_pkg::ssm_out_t out_beat_o
);
  import ssm_pkg::*;

  ssm_cmd_t  cmd;
  ssm_stat_t stat;

  ssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ssm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (in_beat_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_beat_o (out_beat_o)
  );

endmodule

// ----- bench/subsequence_stack_matcher_core_test.sv -----
// ----------------------------------------------------------------------------
// subsequence_stack_matcher_core_test
// Self-checking bench for the subsequence stack matcher. A queue of requests
// is built up front: a directed opening, a random mix of appends, pattern
// pushes, pops and unused request codes, and then a pass that empties the
// stack and pops once more. A clocked driver feeds the requests through
// the valid/stall handshake. A clocked monitor predicts each accepted beat
// from a local copy of the letter lists and the match stack, and compares
// every result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module subsequence_stack_matcher_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_AT    = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int QUIET_FROM = 6000;
  localparam int QUIET_TO   = 9000;
  localparam int RANDOM_REQS = 650;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall_o;
  ssm_in_t  in_beat;
  logic     out_valid_o;
  logic     out_stall;
  ssm_out_t out_beat_o;

  subsequence_stack_matcher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // request queue and the generator's view of word and stack
  ssm_in_t          pending_reqs[$];
  logic [LTR_W-1:0] gen_word[$];
  int               gen_marks[$];
  int               gen_depth  = 0;
  int               gen_cursor = 0;

  // matcher state as predicted from accepted beats
  logic [WIDX_W-1:0] pos_list [ALPHABET][MAX_WORD_LEN];
  int unsigned       pos_count [ALPHABET];
  int unsigned       word_len = 0;
  logic [POS_W-1:0]  match_stk [STACK_DEPTH];
  int unsigned       stk_depth = 0;
  ssm_out_t          expected_results[$];

  int   err_count = 0;
  int   cyc = 0;
  int   hold_left = 0;
  logic in_taken;

  function automatic bit idle_now();
    return (cyc < QUIET_FROM || cyc >= QUIET_TO) && ($urandom_range(0, 99) < 37);
  endfunction

  task automatic queue_req(logic [REQ_W-1:0] req, logic [LTR_W-1:0] ltr);
    ssm_in_t b;
    b.req_type = req;
    b.letter   = ltr;
    pending_reqs = {pending_reqs, b};
    case (req)
      REQ_APPEND: if (gen_word.size() < MAX_WORD_LEN) gen_word = {gen_word, ltr};
      REQ_PUSH: if (gen_depth < STACK_DEPTH) begin
        gen_depth++;
        gen_marks = {gen_marks, gen_cursor};
      end
      REQ_POP: if (gen_depth > 0) begin
        gen_depth--;
        gen_cursor = gen_marks.pop_back();
      end
      default: ;
    endcase
  endtask

  // first listed position of a letter beyond the bound, or none
  function automatic logic [POS_W-1:0] next_position(int unsigned lt, bit bounded,
                                                     logic [POS_W-1:0] bound);
    int unsigned lo, hi, mid;
    lo = 0;
    if (lt >= ALPHABET) return NONE_POS;
    if (bounded && bound >= NONE_POS) return NONE_POS;
    hi = pos_count[lt];
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (bounded && POS_W'(pos_list[lt][mid]) <= bound) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= pos_count[lt]) return NONE_POS;
    return POS_W'(pos_list[lt][lo]);
  endfunction

  task automatic predict_request(ssm_in_t b);
    ssm_out_t    r;
    int unsigned lt;
    logic [POS_W-1:0] p;
    r.answer_yes       = 1'b0;
    r.matched_position = NONE_POS;
    r.status           = STAT_OK;
    lt = b.letter;
    case (b.req_type)
      REQ_APPEND: begin
        if (word_len >= MAX_WORD_LEN) begin
          r.status = STAT_WORD_FULL;
        end else begin
          r.matched_position = POS_W'(word_len);
          if (lt < ALPHABET) begin
            pos_list[lt][pos_count[lt]] = WIDX_W'(word_len);
            pos_count[lt]++;
          end
          word_len++;
        end
      end
      REQ_PUSH: begin
        if (stk_depth >= STACK_DEPTH) begin
          r.status = STAT_STACK_FULL;
        end else begin
          if (stk_depth == 0) p = next_position(lt, 1'b0, '0);
          else p = next_position(lt, 1'b1, match_stk[stk_depth-1]);
          match_stk[stk_depth] = p;
          stk_depth++;
          r.matched_position = p;
          r.answer_yes       = (p != NONE_POS);
        end
      end
      REQ_POP: begin
        if (stk_depth == 0) begin
          r.status = STAT_POP_EMPTY;
        end else begin
          stk_depth--;
          if (stk_depth == 0) begin
            r.answer_yes = 1'b1;
          end else begin
            r.matched_position = match_stk[stk_depth-1];
            r.answer_yes       = (match_stk[stk_depth-1] != NONE_POS);
          end
        end
      end
      default: return;
    endcase
    expected_results = {expected_results, r};
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) cyc <= cyc + 1;
  end

  // long receiver hold-off so the block backs up into its input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (cyc == HOLD_AT) hold_left <= HOLD_LEN;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (pending_reqs.size() != 0 && !idle_now()) begin
          in_beat  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall <= (hold_left != 0) || idle_now();
  end

  ssm_out_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall_o;
      if (in_valid && !in_stall_o) predict_request(in_beat);
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_beat_o.answer_yes !== want.answer_yes)
            report_mismatch($sformatf("answer_yes %0b, want %0b",
                                      out_beat_o.answer_yes, want.answer_yes));
          if (out_beat_o.matched_position !== want.matched_position)
            report_mismatch($sformatf("matched_position %0d, want %0d",
                                      out_beat_o.matched_position, want.matched_position));
          if (out_beat_o.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_beat_o.status, want.status));
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int r, k;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_beat   = '0;
    out_stall = 1'b0;

    // directed opening: empty stack and word, unused code, letters at the edges
    queue_req(REQ_POP, 5'd31);
    queue_req(REQ_PUSH, 5'd0);
    queue_req(REQ_PUSH, 5'd31);
    queue_req(REQ_UNUSED, 5'd21);
    queue_req(REQ_POP, 5'd0);
    queue_req(REQ_POP, 5'd10);
    queue_req(REQ_APPEND, 5'd0);
    queue_req(REQ_APPEND, 5'd25);
    queue_req(REQ_APPEND, 5'd26);
    queue_req(REQ_APPEND, 5'd31);
    queue_req(REQ_APPEND, 5'd0);
    queue_req(REQ_APPEND, 5'd25);
    queue_req(REQ_APPEND, 5'd7);
    queue_req(REQ_PUSH, 5'd0);
    queue_req(REQ_PUSH, 5'd25);
    queue_req(REQ_PUSH, 5'd0);
    queue_req(REQ_PUSH, 5'd25);
    queue_req(REQ_PUSH, 5'd0);
    queue_req(REQ_PUSH, 5'd7);
    queue_req(REQ_POP, 5'd21);
    queue_req(REQ_POP, 5'd3);
    queue_req(REQ_PUSH, 5'd7);
    queue_req(REQ_PUSH, 5'd30);
    queue_req(REQ_POP, 5'd0);
    queue_req(REQ_UNUSED, 5'd10);

    // random mix, mostly patterns that follow the word
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30 && gen_word.size() < 600) begin
        k = $urandom_range(0, 9);
        if (k < 5) queue_req(REQ_APPEND, LTR_W'($urandom_range(0, 3)));
        else if (k < 9) queue_req(REQ_APPEND, LTR_W'($urandom_range(0, ALPHABET-1)));
        else queue_req(REQ_APPEND, LTR_W'($urandom_range(0, 31)));
      end else if (r < 70) begin
        if (gen_cursor < gen_word.size() && $urandom_range(0, 99) < 80) begin
          k = gen_cursor + $urandom_range(0, 3);
          if (k >= gen_word.size()) k = gen_word.size() - 1;
          queue_req(REQ_PUSH, gen_word[k]);
          gen_cursor = k + 1;
        end else begin
          queue_req(REQ_PUSH, LTR_W'($urandom_range(0, 31)));
        end
      end else if (r < 94) begin
        queue_req(REQ_POP, LTR_W'($urandom_range(0, 31)));
      end else begin
        queue_req(REQ_UNUSED, LTR_W'($urandom_range(0, 31)));
      end
    end

    // empty the stack, then pop once more on the empty stack
    while (gen_depth > 0) queue_req(REQ_POP, LTR_W'($urandom_range(0, 31)));
    queue_req(REQ_POP, LTR_W'($urandom_range(0, 31)));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
